/* rtl/wbps_pkg.sv */
// Shared types, constants and register indexes for the wildcard byte pattern scanner.
`default_nettype none

package wbps_pkg;

  localparam int MAX_PATTERN_DEFAULT = 32;
  localparam int OFFSET_BITS_DEFAULT = 32;

  localparam int CFG_DATA_W  = 64;
  localparam int CFG_IDX_W   = 3;
  localparam int LEN_REG_W   = 6;
  localparam int PAT_REGS    = 4;
  localparam int PAT_BYTES   = PAT_REGS * CFG_DATA_W / 8;
  localparam int OFFSET_OUT_W = 32;

  localparam logic [7:0] WILDCARD_BYTE = 8'h2A;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_LENGTH = 3'd0,
    CFG_PATTERN_0_7    = 3'd1,
    CFG_PATTERN_8_15   = 3'd2,
    CFG_PATTERN_16_23  = 3'd3,
    CFG_PATTERN_24_31  = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] region_byte;
    logic       region_end;
  } in_t;

  typedef struct packed {
    logic                    found;
    logic [OFFSET_OUT_W-1:0] match_offset;
  } out_t;

  // Status of the transaction held in the window stage.
  typedef struct packed {
    logic valid;
    logic last;
    logic armed;
  } win_stat_t;

endpackage

`default_nettype wire

/* rtl/wildcard_byte_pattern_scanner_core.sv */
// Top level of the wildcard byte pattern scanner: handshake, stages and result register.
// A transaction that causes a result passes the window stage register, then the result
// register; out_valid_o is set as the result register loads.
// Throughput: one region byte per cycle; the input stalls only while the window stage holds
// a transaction and the result register holds a result that waits on out_stall_i.
// Reset clears all control state, sets pattern_length to 1 and the pattern bytes to zero;
// the byte window itself is not cleared and needs no clearing pass.
`default_nettype none

module wildcard_byte_pattern_scanner_core #(
  parameter int MAX_PATTERN = wbps_pkg::MAX_PATTERN_DEFAULT,
  parameter int OFFSET_BITS = wbps_pkg::OFFSET_BITS_DEFAULT
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [wbps_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [wbps_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  wire logic                             in_valid_i,
  input  wire wbps_pkg::in_t                    in_data_i,
  output logic                                  in_stall_o,
  output logic                                  out_valid_o,
  output wbps_pkg::out_t                        out_data_o,
  input  wire logic                             out_stall_i
);

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);

  logic [LEN_W-1:0]            len;
  logic [MAX_PATTERN-1:0][7:0] aligned;
  logic [MAX_PATTERN-1:0][7:0] window;
  logic [OFFSET_BITS-1:0]      count;
  wbps_pkg::win_stat_t         stat;
  logic                        advance;
  logic                        load;
  logic                        drain;
  logic                        produce;
  wbps_pkg::out_t              result;
  logic                        out_valid_q, out_valid_d;
  wbps_pkg::out_t              out_q;

  // The window stage moves on whenever the result register is free or being taken.
  assign advance    = !out_valid_q || !out_stall_i;
  assign drain      = stat.valid && advance;
  assign in_stall_o = stat.valid && !advance;
  assign load       = in_valid_i && !in_stall_o;

  wbps_cfg #(
    .MAX_PATTERN (MAX_PATTERN),
    .LEN_W       (LEN_W)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .len_o      (len),
    .aligned_o  (aligned)
  );

  wbps_window #(
    .MAX_PATTERN (MAX_PATTERN),
    .OFFSET_BITS (OFFSET_BITS),
    .LEN_W       (LEN_W)
  ) u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (load),
    .drain_i   (drain),
    .in_data_i (in_data_i),
    .len_i     (len),
    .window_o  (window),
    .count_o   (count),
    .stat_o    (stat)
  );

  wbps_match #(
    .MAX_PATTERN (MAX_PATTERN),
    .OFFSET_BITS (OFFSET_BITS),
    .LEN_W       (LEN_W)
  ) u_match (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .stat_i    (stat),
    .window_i  (window),
    .aligned_i (aligned),
    .count_i   (count),
    .len_i     (len),
    .produce_o (produce),
    .result_o  (result)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (drain && produce) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (drain && produce) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_no_result_offset_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.found) |-> (out_q.match_offset == '0))
    else $error("no-match result carries a nonzero offset");

  a_stall_needs_full_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (stat.valid && out_valid_q && out_stall_i))
    else $error("input stalled while the pipeline has room");

  a_stage_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stat.valid && !out_valid_q && !load) |=> !stat.valid)
    else $error("window stage held a transaction with a free result register");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> (out_valid_q && $stable(out_q)))
    else $error("stalled result changed or was dropped");
`endif

endmodule

`default_nettype wire

/* rtl/wbps_cfg.sv */
// Configuration registers and the pattern aligned to the byte window.
`default_nettype none

module wbps_cfg #(
  parameter int MAX_PATTERN = wbps_pkg::MAX_PATTERN_DEFAULT,
  parameter int LEN_W       = $clog2(MAX_PATTERN + 1)
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [wbps_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [wbps_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  output logic      [LEN_W-1:0]                     len_o,
  output logic      [MAX_PATTERN-1:0][7:0]          aligned_o
);

  localparam int RAW_W = wbps_pkg::LEN_REG_W + 1;

  logic [wbps_pkg::LEN_REG_W-1:0]                        len_q;
  logic [wbps_pkg::PAT_REGS-1:0][wbps_pkg::CFG_DATA_W-1:0] pat_q;
  logic [wbps_pkg::PAT_BYTES-1:0][7:0]                   pat_bytes;
  logic [RAW_W-1:0]                                      len_raw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= wbps_pkg::LEN_REG_W'(1);
      pat_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        wbps_pkg::CFG_PATTERN_LENGTH: len_q    <= cfg_data_i[wbps_pkg::LEN_REG_W-1:0];
        wbps_pkg::CFG_PATTERN_0_7:    pat_q[0] <= cfg_data_i;
        wbps_pkg::CFG_PATTERN_8_15:   pat_q[1] <= cfg_data_i;
        wbps_pkg::CFG_PATTERN_16_23:  pat_q[2] <= cfg_data_i;
        wbps_pkg::CFG_PATTERN_24_31:  pat_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign pat_bytes = pat_q;
  assign len_raw   = {1'b0, len_q};

  // A length of zero behaves as one; anything past the window depth is clipped.
  always_comb begin
    if (len_raw == '0) begin
      len_o = LEN_W'(1);
    end else if (len_raw > RAW_W'(MAX_PATTERN)) begin
      len_o = LEN_W'(MAX_PATTERN);
    end else begin
      len_o = LEN_W'(len_raw);
    end
  end

  // Window slot j (newest first) lines up with pattern byte len-1-j. Slots past
  // the active length see a wildcard so they never block a match.
  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_slot
    logic [MAX_PATTERN-1:0][7:0] cand;
    logic [MAX_PATTERN-1:0]      hit_k;
    for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_src
      if (k + j + 1 <= MAX_PATTERN) begin : g_fit
        assign hit_k[k] = (LEN_W'(k + j + 1) == len_o);
      end else begin : g_nofit
        assign hit_k[k] = 1'b0;
      end
      if (k < wbps_pkg::PAT_BYTES) begin : g_reg
        assign cand[k] = hit_k[k] ? pat_bytes[k] : 8'h00;
      end else begin : g_zero
        assign cand[k] = 8'h00;
      end
    end
    always_comb begin
      aligned_o[j] = (LEN_W'(j) < len_o) ? 8'h00 : wbps_pkg::WILDCARD_BYTE;
      for (int k = 0; k < MAX_PATTERN; k++) begin
        aligned_o[j] = aligned_o[j] | cand[k];
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/wbps_window.sv */
// Window stage: shift register of recent region bytes and the saturating byte count.
`default_nettype none

module wbps_window #(
  parameter int MAX_PATTERN = wbps_pkg::MAX_PATTERN_DEFAULT,
  parameter int OFFSET_BITS = wbps_pkg::OFFSET_BITS_DEFAULT,
  parameter int LEN_W       = $clog2(MAX_PATTERN + 1)
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          load_i,
  input  wire logic                          drain_i,
  input  wire wbps_pkg::in_t                 in_data_i,
  input  wire logic [LEN_W-1:0]              len_i,
  output logic      [MAX_PATTERN-1:0][7:0]   window_o,
  output logic      [OFFSET_BITS-1:0]        count_o,
  output wbps_pkg::win_stat_t                stat_o
);

  logic [MAX_PATTERN-1:0][7:0] window_q;
  logic [OFFSET_BITS-1:0]      count_q, count_d, count_base;
  logic                        valid_q, valid_d;
  logic                        last_q;

  // The last flag of the previous transaction stays until the next load, so a
  // new region restarts its count here.
  assign count_base = last_q ? '0 : count_q;
  assign count_d    = (&count_base) ? count_base : count_base + OFFSET_BITS'(1);

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (drain_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      last_q  <= 1'b0;
      count_q <= '0;
    end else begin
      valid_q <= valid_d;
      if (load_i) begin
        last_q  <= in_data_i.region_end;
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      window_q <= {window_q[MAX_PATTERN-2:0], in_data_i.region_byte};
    end
  end

  assign window_o     = window_q;
  assign count_o      = count_q;
  assign stat_o.valid = valid_q;
  assign stat_o.last  = last_q;
  assign stat_o.armed = (count_q >= OFFSET_BITS'(len_i));

endmodule

`default_nettype wire

/* rtl/wbps_match.sv */
// Parallel byte compare against the aligned pattern and per-region match tracking.
`default_nettype none

module wbps_match #(
  parameter int MAX_PATTERN = wbps_pkg::MAX_PATTERN_DEFAULT,
  parameter int OFFSET_BITS = wbps_pkg::OFFSET_BITS_DEFAULT,
  parameter int LEN_W       = $clog2(MAX_PATTERN + 1)
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          advance_i,
  input  wire wbps_pkg::win_stat_t           stat_i,
  input  wire logic [MAX_PATTERN-1:0][7:0]   window_i,
  input  wire logic [MAX_PATTERN-1:0][7:0]   aligned_i,
  input  wire logic [OFFSET_BITS-1:0]        count_i,
  input  wire logic [LEN_W-1:0]              len_i,
  output logic                               produce_o,
  output wbps_pkg::out_t                     result_o
);

  logic                   done_q;
  logic [MAX_PATTERN-1:0] byte_ok;
  logic                   hit;
  logic                   fire;
  logic [OFFSET_BITS-1:0] start;

  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cmp
    assign byte_ok[j] = (aligned_i[j] == wbps_pkg::WILDCARD_BYTE) ||
                        (aligned_i[j] == window_i[j]);
  end

  assign fire      = stat_i.valid && advance_i;
  assign hit       = stat_i.armed && !done_q && (&byte_ok);
  assign produce_o = stat_i.valid && (hit || (stat_i.last && !done_q));
  assign start     = count_i - OFFSET_BITS'(len_i);

  assign result_o.found        = hit;
  assign result_o.match_offset = hit ? wbps_pkg::OFFSET_OUT_W'(start) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else if (fire) begin
      if (stat_i.last) begin
        done_q <= 1'b0;
      end else if (hit) begin
        done_q <= 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_hit_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !hit)
    else $error("pattern hit reported twice in one region");
`endif

endmodule

`default_nettype wire

/* bench/tb_top.sv */
// Testbench for the wildcard byte pattern scanner: random regions checked by a scoreboard.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [7:0] byte_q_t[$];

  // Tracks the scanner state and queues the match results it should report.
  class match_scoreboard;
    logic [wbps_pkg::LEN_REG_W-1:0]  len_reg;
    logic [wbps_pkg::CFG_DATA_W-1:0] pat_regs[wbps_pkg::PAT_REGS];
    logic [7:0]                      window[32];
    logic [31:0]                     bytes_seen;
    bit                              match_done;
    wbps_pkg::out_t                  expected_matches[$];
    int                              errors;

    function new();
      len_reg = 6'd1;
      foreach (pat_regs[i]) pat_regs[i] = '0;
      errors = 0;
      clear_region();
    endfunction

    function void clear_region();
      foreach (window[i]) window[i] = 8'h00;
      bytes_seen = '0;
      match_done = 1'b0;
    endfunction

    function void write_reg(wbps_pkg::cfg_idx_e idx, logic [wbps_pkg::CFG_DATA_W-1:0] data);
      if (idx == wbps_pkg::CFG_PATTERN_LENGTH) begin
        len_reg = data[wbps_pkg::LEN_REG_W-1:0];
      end else begin
        pat_regs[int'(idx) - int'(wbps_pkg::CFG_PATTERN_0_7)] = data;
      end
    endfunction

    function int unsigned active_len();
      if (len_reg == 0) return 1;
      if (len_reg > 32) return 32;
      return len_reg;
    endfunction

    function logic [7:0] pattern_at(int unsigned k);
      return pat_regs[k / 8][(k % 8) * 8 +: 8];
    endfunction

    function int pending();
      return expected_matches.size();
    endfunction

    function void note_byte(wbps_pkg::in_t item);
      int unsigned    len;
      bit             hit;
      wbps_pkg::out_t res;
      len = active_len();
      for (int i = 31; i > 0; i--) window[i] = window[i - 1];
      window[0] = item.region_byte;
      if (bytes_seen != 32'hFFFF_FFFF) bytes_seen++;
      if (!match_done && bytes_seen >= len) begin
        hit = 1'b1;
        for (int i = 0; i < len; i++) begin
          if (pattern_at(i) != wbps_pkg::WILDCARD_BYTE &&
              pattern_at(i) != window[len - 1 - i]) hit = 1'b0;
        end
        if (hit) begin
          match_done = 1'b1;
          res.found = 1'b1;
          res.match_offset = bytes_seen - len;
          expected_matches.push_back(res);
        end
      end
      if (item.region_end) begin
        if (!match_done) begin
          res.found = 1'b0;
          res.match_offset = '0;
          expected_matches.push_back(res);
        end
        clear_region();
      end
    endfunction

    function void flag(string field, longint unsigned want, longint unsigned got);
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endfunction

    function void check_match(wbps_pkg::out_t got);
      wbps_pkg::out_t want;
      if (expected_matches.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual found=%0d offset=%0d",
                 $time, got.found, got.match_offset);
        return;
      end
      want = expected_matches.pop_front();
      if (got.found !== want.found) flag("found", want.found, got.found);
      if (got.match_offset !== want.match_offset)
        flag("match_offset", want.match_offset, got.match_offset);
    endfunction
  endclass

  logic                            clk_i = 1'b0;
  logic                            rst_ni;
  logic                            cfg_we_i;
  logic [wbps_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [wbps_pkg::CFG_DATA_W-1:0] cfg_data_i;
  logic                            in_valid_i;
  wbps_pkg::in_t                   in_data_i;
  logic                            in_stall_o;
  logic                            out_valid_o;
  wbps_pkg::out_t                  out_data_o;
  logic                            out_stall_i;

  match_scoreboard sb = new();
  bit              idle_on = 1'b1;
  bit              hold_req = 1'b0;
  int              items_sent = 0;

  wildcard_byte_pattern_scanner_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i)
  );

  always #5 clk_i = ~clk_i;

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(input logic [7:0] b, input logic last);
    wbps_pkg::in_t it;
    it.region_byte = b;
    it.region_end  = last;
    while (idle_on && $urandom_range(99) < 36) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i  = it;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_byte(it);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_region(input byte_q_t bytes);
    foreach (bytes[i]) send_item(bytes[i], i == bytes.size() - 1);
  endtask

  // Drops in_valid_i and waits until every expected result has come.
  task automatic settle();
    in_valid_i = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_cfg(input wbps_pkg::cfg_idx_e idx,
                           input logic [wbps_pkg::CFG_DATA_W-1:0] data);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  function automatic logic [wbps_pkg::CFG_DATA_W-1:0] pattern_word(int mode);
    logic [wbps_pkg::CFG_DATA_W-1:0] w;
    w = {$urandom, $urandom};
    case (mode)
      0: w = {8{wbps_pkg::WILDCARD_BYTE}};
      1: w = '1;
      2: w = '0;
      3: ;
      default: begin
        for (int k = 0; k < 8; k++) begin
          if ($urandom_range(3) == 0) w[k * 8 +: 8] = wbps_pkg::WILDCARD_BYTE;
        end
      end
    endcase
    return w;
  endfunction

  task automatic random_config(input int phase);
    logic [wbps_pkg::CFG_DATA_W-1:0] len_word;
    int                              mode;
    len_word = {$urandom, $urandom};
    case (phase % 8)
      0: len_word[5:0] = 6'd0;
      1: len_word[5:0] = 6'd1;
      2: len_word[5:0] = 6'd32;
      3: len_word[5:0] = 6'($urandom_range(33, 62));
      4: len_word[5:0] = 6'd63;
      default: len_word[5:0] = 6'($urandom_range(1, 32));
    endcase
    write_cfg(wbps_pkg::CFG_PATTERN_LENGTH, len_word);
    mode = $urandom_range(9);
    for (int k = 0; k < wbps_pkg::PAT_REGS; k++) begin
      if (phase == 0 || $urandom_range(3) != 0)
        write_cfg(wbps_pkg::cfg_idx_e'(int'(wbps_pkg::CFG_PATTERN_0_7) + k),
                  pattern_word(mode));
    end
  endtask

  // Mostly bytes borrowed from the pattern so that partial matches are common.
  task automatic random_region();
    int unsigned len, n, at;
    byte_q_t     q;
    bit          noise;
    logic [7:0]  p;
    len   = sb.active_len();
    noise = ($urandom_range(9) == 0);
    n = ($urandom_range(9) == 0) ? $urandom_range(1, 100) : $urandom_range(1, 2 * len + 6);
    for (int i = 0; i < n; i++) begin
      p = sb.pattern_at($urandom_range(0, len - 1));
      if (noise || p == wbps_pkg::WILDCARD_BYTE || $urandom_range(99) < 40) p = 8'($urandom);
      q.push_back(p);
    end
    if (!noise && n >= len && $urandom_range(99) < 55) begin
      at = $urandom_range(0, n - len);
      for (int k = 0; k < len; k++) begin
        if (sb.pattern_at(k) != wbps_pkg::WILDCARD_BYTE) q[at + k] = sb.pattern_at(k);
      end
    end
    send_region(q);
  endtask

  // Result side: random stalls, plus a long hold-off on request.
  initial begin
    int hold_cnt;
    hold_cnt = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) sb.check_match(out_data_o);
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = 300;
      end
      if (hold_cnt > 0) begin
        out_stall_i = 1'b1;
        hold_cnt--;
      end else begin
        out_stall_i = idle_on && ($urandom_range(99) < 36);
      end
    end
  end

  initial begin
    int phase;
    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = wbps_pkg::CFG_PATTERN_LENGTH;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reset pattern is a single 0x00: a match on the last byte, a miss, and
    // silence after a match including the region's last byte.
    send_region('{8'h00});
    send_region('{8'hFF});
    send_region('{8'hFF, 8'h00, 8'h00});
    // A length of zero acts as one.
    settle();
    write_cfg(wbps_pkg::CFG_PATTERN_LENGTH, 64'd0);
    write_cfg(wbps_pkg::CFG_PATTERN_0_7, 64'h0000_0000_0000_00FF);
    send_region('{8'h12, 8'hFF, 8'hFF});
    // All wildcards: too few bytes first, then a full window on the last byte.
    settle();
    write_cfg(wbps_pkg::CFG_PATTERN_LENGTH, 64'd4);
    write_cfg(wbps_pkg::CFG_PATTERN_0_7, 64'h0000_0000_2A2A_2A2A);
    send_region('{8'h01, 8'h02, 8'h03});
    send_region('{8'h01, 8'h02, 8'h03, 8'h04});
    // Wildcard in the middle of a fixed pattern.
    settle();
    write_cfg(wbps_pkg::CFG_PATTERN_LENGTH, 64'd3);
    write_cfg(wbps_pkg::CFG_PATTERN_0_7, 64'h0000_0000_0043_2A41);
    send_region('{8'h41, 8'h99, 8'h43, 8'h00, 8'h41, 8'h00, 8'h43});

    phase = 0;
    while (items_sent < 1550) begin
      settle();
      random_config(phase);
      idle_on = !(phase == 5 || phase == 6);
      if (phase == 2) hold_req = 1'b1;
      repeat ($urandom_range(3, 6)) random_region();
      phase++;
    end
    idle_on = 1'b1;
    settle();
    repeat (4) @(negedge clk_i);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      if (sb.pending() != 0)
        $display("%0t: %0d expected results never arrived", $time, sb.pending());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
